/* rtl/core/nrt_pkg.sv */
// Shared constants for the nonce replay table.
`timescale 1ns / 1ps
package nrt_pkg;
    localparam int MAP_SLOTS_DEF   = 1024;
    localparam int QUEUE_DEPTH_DEF = 512;

    localparam int NONCE_W  = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;
    localparam int TMO_W    = 16;
    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = 32;
    localparam int M_DATA_W = 56;

    localparam logic [CMD_W-1:0] CMD_ISSUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_USE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic [CFG_AW-1:0] REG_TIMEOUT = 1'd0;
    localparam logic [CFG_AW-1:0] REG_MARKER  = 1'd1;

    localparam logic [TMO_W-1:0]   TIMEOUT_RST = 16'd60;
    localparam logic [NONCE_W-1:0] MARKER_RST  = 32'hFFFF_FFFF;
endpackage

/* rtl/core/nrt_ram.sv */
// Simple dual-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module nrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* rtl/core/nonce_replay_table_core.sv */
// Top level: nonce replay table sequencer with map and issue-queue memories.
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tuser: command, s_tdata: nonce_value
// m_        out  m_tvalid/m_tready  m_tuser: status, m_tdata: nonce_out, live, expired
// cfg_      in   cfg_we             cfg_addr, cfg_wdata
//
// Issue/use: hash (low key bits for power-of-two MAP_SLOTS, else a radix-16 remainder),
// then linear map probes; a found use then scans the queue for its entry.
// Tick: pops expired entries from the queue front, clears the whole map, then rehashes
// and reinserts each live queue entry.
// After reset the map is cleared with s_tready low.
// One request at a time; a result waits in the output register while the next is taken.
`timescale 1ns / 1ps
module nonce_replay_table_core #(
    parameter int MAP_SLOTS   = nrt_pkg::MAP_SLOTS_DEF,
    parameter int QUEUE_DEPTH = nrt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] nonce_value
    input  logic [nrt_pkg::CMD_W-1:0]     s_tuser,   // [1:0] command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nrt_pkg::M_DATA_W-1:0]  m_tdata,   // [31:0] nonce_out, [40:32] live_count,
                                                     // [49:41] expired_count, [55:50] zero
    output logic [nrt_pkg::STATUS_W-1:0]  m_tuser,   // [2:0] status
    input  logic                          cfg_we,
    input  logic [nrt_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [nrt_pkg::CFG_DW-1:0]    cfg_wdata
);
    localparam int MAW = $clog2(MAP_SLOTS);
    localparam int NW  = $clog2(MAP_SLOTS + 1);
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QW  = 2 * nrt_pkg::NONCE_W + 1;
    localparam bit MAP_POW2 = (MAP_SLOTS & (MAP_SLOTS - 1)) == 0;
    localparam logic [MAW-1:0] MAP_LAST = MAW'(MAP_SLOTS - 1);
    localparam logic [NW-1:0]  MAP_N    = NW'(MAP_SLOTS);
    localparam logic [QAW-1:0] Q_LAST   = QAW'(QUEUE_DEPTH - 1);
    localparam logic [QAW-1:0] Q_DEPTH  = QAW'(QUEUE_DEPTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_MRD   = 3'd3;
    localparam logic [2:0] S_MCHK  = 3'd4;
    localparam logic [2:0] S_QRD   = 3'd5;
    localparam logic [2:0] S_QCHK  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [2:0] MD_ISSUE = 3'd0;
    localparam logic [2:0] MD_USE   = 3'd1;
    localparam logic [2:0] MD_USCAN = 3'd2;
    localparam logic [2:0] MD_EXP   = 3'd3;
    localparam logic [2:0] MD_REB   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  mode_reg, mode_next;
    logic [31:0] key_reg, key_next;
    logic [MAW-1:0] midx_reg, midx_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [QAW-1:0] qidx_reg, qidx_next;
    logic [QAW-1:0] front_reg, front_next;
    logic [QAW-1:0] back_reg, back_next;
    logic [QAW-1:0] live_reg, live_next;
    logic [QAW-1:0] exp_reg, exp_next;
    logic [31:0] time_reg, time_next;
    logic [15:0] timeout_reg, timeout_next;
    logic [31:0] marker_reg, marker_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] nout_reg, nout_next;
    logic [MAW-1:0] rem_reg, rem_next;
    logic [2:0]  hbit_reg, hbit_next;
    logic        init_reg, init_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [nrt_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [2:0]  m_tuser_reg, m_tuser_next;

    logic           map_we, map_re;
    logic [MAW-1:0] map_waddr;
    logic [31:0]    map_wdata, map_q;
    logic           q_we, q_re;
    logic [QAW-1:0] q_waddr;
    logic [QW-1:0]  q_wdata, q_q;

    logic [QAW-1:0] qcount, q_inc;
    logic [MAW-1:0] m_inc;
    logic [MAW+3:0] rem_sh, rem_dig;
    logic [31:0]    q_nonce, q_time;
    logic           q_used;

    nrt_ram #(.WIDTH(32), .DEPTH(MAP_SLOTS)) u_map (
        .aclk(aclk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .re(map_re), .raddr(midx_reg), .rdata(map_q)
    );

    nrt_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .re(q_re), .raddr(qidx_reg), .rdata(q_q)
    );

    assign qcount  = back_reg - front_reg + ((back_reg < front_reg) ? Q_DEPTH : '0);
    assign q_inc   = (qidx_reg == Q_LAST) ? '0 : qidx_reg + 1'b1;
    assign m_inc   = (midx_reg == MAP_LAST) ? '0 : midx_reg + 1'b1;
    assign rem_sh  = {rem_reg, key_reg[{hbit_reg, 2'b00} +: 4]};
    assign q_nonce = q_q[31:0];
    assign q_time  = q_q[63:32];
    assign q_used  = q_q[64];

    // radix-16 remainder step against constant multiples of MAP_SLOTS
    always_comb begin
        rem_dig = rem_sh;
        for (int j = 1; j < 16; j++) begin
            if (rem_sh >= (MAW + 4)'(j * MAP_SLOTS)) begin
                rem_dig = rem_sh - (MAW + 4)'(j * MAP_SLOTS);
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next = state_reg;
        mode_next = mode_reg;
        key_next = key_reg;
        midx_next = midx_reg;
        n_next = n_reg;
        qidx_next = qidx_reg;
        front_next = front_reg;
        back_next = back_reg;
        live_next = live_reg;
        exp_next = exp_reg;
        time_next = time_reg;
        timeout_next = timeout_reg;
        marker_next = marker_reg;
        status_next = status_reg;
        nout_next = nout_reg;
        rem_next = rem_reg;
        hbit_next = hbit_reg;
        init_next = init_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        map_we = 1'b0;
        map_re = 1'b0;
        map_waddr = midx_reg;
        map_wdata = '0;
        q_we = 1'b0;
        q_re = 1'b0;
        q_waddr = qidx_reg;
        q_wdata = q_q;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cfg_we) begin
            if (cfg_addr == nrt_pkg::REG_TIMEOUT) begin
                timeout_next = cfg_wdata[15:0];
            end else begin
                marker_next = cfg_wdata;
            end
        end

        unique case (state_reg)
            S_CLEAR: begin
                map_we = 1'b1;
                map_wdata = '0;
                if (midx_reg == MAP_LAST) begin
                    if (init_reg) begin
                        init_next = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        mode_next = MD_REB;
                        qidx_next = front_reg;
                        state_next = S_QRD;
                    end
                end else begin
                    midx_next = m_inc;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    key_next = s_tdata;
                    status_next = nrt_pkg::ST_OK;
                    nout_next = '0;
                    exp_next = '0;
                    rem_next = '0;
                    hbit_next = 3'd7;
                    n_next = '0;
                    state_next = S_DONE;
                    unique case (s_tuser)
                        nrt_pkg::CMD_ISSUE: begin
                            mode_next = MD_ISSUE;
                            if (qcount >= Q_LAST) begin
                                status_next = nrt_pkg::ST_FULL;
                            end else if (s_tdata == '0 || s_tdata == marker_reg) begin
                                status_next = nrt_pkg::ST_RESERVED;
                            end else begin
                                state_next = S_HASH;
                            end
                        end
                        nrt_pkg::CMD_USE: begin
                            mode_next = MD_USE;
                            if (s_tdata == '0 || s_tdata == marker_reg) begin
                                status_next = nrt_pkg::ST_RESERVED;
                            end else begin
                                state_next = S_HASH;
                            end
                        end
                        nrt_pkg::CMD_TICK: begin
                            mode_next = MD_EXP;
                            time_next = time_reg + 1'b1;
                            qidx_next = front_reg;
                            state_next = S_QRD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HASH: begin
                n_next = '0;
                if (MAP_POW2) begin
                    midx_next = key_reg[MAW-1:0];
                    state_next = S_MRD;
                end else begin
                    rem_next = rem_dig[MAW-1:0];
                    hbit_next = hbit_reg - 1'b1;
                    if (hbit_reg == '0) begin
                        midx_next = rem_next;
                        state_next = S_MRD;
                    end
                end
            end
            S_MRD: begin
                map_re = 1'b1;
                state_next = S_MCHK;
            end
            S_MCHK: begin
                if (mode_reg == MD_USE) begin
                    if (map_q == '0) begin
                        status_next = nrt_pkg::ST_NOTFOUND;
                        state_next = S_DONE;
                    end else if (map_q == key_reg) begin
                        map_we = 1'b1;
                        map_wdata = marker_reg;
                        nout_next = key_reg;
                        mode_next = MD_USCAN;
                        qidx_next = front_reg;
                        state_next = S_QRD;
                    end else if (n_reg + 1'b1 == MAP_N) begin
                        status_next = nrt_pkg::ST_NOTFOUND;
                        state_next = S_DONE;
                    end else begin
                        n_next = n_reg + 1'b1;
                        midx_next = m_inc;
                        state_next = S_MRD;
                    end
                end else begin
                    if (map_q == '0) begin
                        map_we = 1'b1;
                        map_wdata = key_reg;
                        if (mode_reg == MD_ISSUE) begin
                            q_we = 1'b1;
                            q_waddr = back_reg;
                            q_wdata = {1'b0, time_reg, key_reg};
                            back_next = (back_reg == Q_LAST) ? '0 : back_reg + 1'b1;
                            live_next = live_reg + 1'b1;
                            nout_next = key_reg;
                            state_next = S_DONE;
                        end else begin
                            qidx_next = q_inc;
                            state_next = S_QRD;
                        end
                    end else if (map_q == key_reg || n_reg + 1'b1 == MAP_N) begin
                        if (mode_reg == MD_ISSUE) begin
                            status_next = (map_q == key_reg) ? nrt_pkg::ST_DUP
                                                             : nrt_pkg::ST_FULL;
                            state_next = S_DONE;
                        end else begin
                            qidx_next = q_inc;
                            state_next = S_QRD;
                        end
                    end else begin
                        n_next = n_reg + 1'b1;
                        midx_next = m_inc;
                        state_next = S_MRD;
                    end
                end
            end
            S_QRD: begin
                if (qidx_reg == back_reg) begin
                    if (mode_reg == MD_EXP) begin
                        midx_next = '0;
                        state_next = S_CLEAR;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    q_re = 1'b1;
                    state_next = S_QCHK;
                end
            end
            S_QCHK: begin
                unique case (mode_reg)
                    MD_EXP: begin
                        if (time_reg - q_time >= {16'd0, timeout_reg}) begin
                            if (!q_used && live_reg != '0) begin
                                live_next = live_reg - 1'b1;
                            end
                            front_next = q_inc;
                            qidx_next = q_inc;
                            exp_next = exp_reg + 1'b1;
                            state_next = S_QRD;
                        end else begin
                            midx_next = '0;
                            state_next = S_CLEAR;
                        end
                    end
                    MD_USCAN: begin
                        if (!q_used && q_nonce == key_reg) begin
                            q_we = 1'b1;
                            q_wdata = {1'b1, q_time, q_nonce};
                            if (live_reg != '0) begin
                                live_next = live_reg - 1'b1;
                            end
                            state_next = S_DONE;
                        end else begin
                            qidx_next = q_inc;
                            state_next = S_QRD;
                        end
                    end
                    default: begin
                        if (!q_used && q_nonce != '0 && q_nonce != marker_reg) begin
                            key_next = q_nonce;
                            rem_next = '0;
                            hbit_next = 3'd7;
                            state_next = S_HASH;
                        end else begin
                            qidx_next = q_inc;
                            state_next = S_QRD;
                        end
                    end
                endcase
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next = status_reg;
                    m_tdata_next = {6'd0, nrt_pkg::COUNT_W'(exp_reg),
                                    nrt_pkg::COUNT_W'(live_reg), nout_reg};
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            mode_reg <= MD_ISSUE;
            midx_reg <= '0;
            front_reg <= '0;
            back_reg <= '0;
            live_reg <= '0;
            time_reg <= '0;
            timeout_reg <= nrt_pkg::TIMEOUT_RST;
            marker_reg <= nrt_pkg::MARKER_RST;
            init_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            midx_reg <= midx_next;
            front_reg <= front_next;
            back_reg <= back_next;
            live_reg <= live_next;
            time_reg <= time_next;
            timeout_reg <= timeout_next;
            marker_reg <= marker_next;
            init_reg <= init_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        n_reg <= n_next;
        qidx_reg <= qidx_next;
        exp_reg <= exp_next;
        status_reg <= status_next;
        nout_reg <= nout_next;
        rem_reg <= rem_next;
        hbit_reg <= hbit_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end
endmodule
